@@ rtl/core/cct_pkg.sv @@
`default_nettype none

package cct_pkg;

  typedef struct packed {
    logic [2:0]        action;
    logic [15:0]       cmd_temp;
    logic [6:0]        cmd_level;
    logic [1:0]        cmd_mode;
    logic [15:0]       lux_sample;
    logic signed [7:0] encoder_delta;
  } item_t;

  typedef struct packed {
    logic [15:0] warm_level;
    logic [15:0] cool_level;
    logic [15:0] shown_temp;
    logic [6:0]  shown_level;
  } result_t;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CMD     = 3'd1;
  localparam logic [2:0] ACT_AMBIENT = 3'd2;
  localparam logic [2:0] ACT_ENCODER = 3'd3;
  localparam logic [2:0] ACT_BUTTON  = 3'd4;

  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;

  localparam logic [1:0] CFG_LUX_GOAL  = 2'd0;
  localparam logic [1:0] CFG_RAMP_STEP = 2'd1;
  localparam logic [1:0] CFG_ENC_GAIN  = 2'd2;

  localparam logic [15:0] LUX_GOAL_RST  = 16'd500;
  localparam logic [9:0]  RAMP_STEP_RST = 10'd10;
  localparam logic [3:0]  ENC_GAIN_RST  = 4'd2;
  localparam logic [15:0] TEMP_RST      = 16'd4000;
  localparam logic [6:0]  LEVEL_RST     = 7'd60;

  localparam logic [15:0] WARM_K     = 16'd1800;
  localparam logic [15:0] COOL_K     = 16'd6500;
  localparam logic [15:0] BTN_LOW_K  = 16'd3000;
  localparam logic [15:0] BTN_MID_K  = 16'd5500;
  localparam logic [15:0] BTN_NEXT_K = 16'd4500;
  localparam logic [6:0]  LEVEL_MAX  = 7'd100;

  // (COOL_K - WARM_K) * 100, divisor of the blend
  localparam int          SPAN_W   = 19;
  localparam logic [18:0] SPAN_DEN = 19'd470000;

endpackage

`default_nettype wire

@@ rtl/core/cct_lamp_dimming_controller.sv @@
`default_nettype none

// Warm/cool white lamp dimming controller.
// item channel (item_valid / item_stall / item): one event per beat. The block
//   takes one event at a time; item_stall is high while an event is in work.
// result channel (result_valid / result_stall / result): at most one beat per
//   event, carrying warm/cool PWM levels and the shown temperature/level.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is
//   always high; write only while the block is idle.
// Sequence: commands and events with no result complete in the idle state, except
//   an ambient sample that runs the lux divide and then leaves the level as it is.
//   An event with a result runs a serial multiply and then the bit-serial divide
//   by the blend span; an ambient sample first runs a bit-serial divide by lux_goal.
// Results go to an output register: the next event is taken while a result
//   waits. If result_stall holds and a second result is ready, the block waits
//   with item_stall high until the register frees.
// Reset (rst, synchronous) restores 4000 K / level 60 / auto mode and the
//   register defaults; no result is pending afterwards.
module cct_lamp_dimming_controller #(
  parameter int LEVEL_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  cct_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output cct_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  import cct_pkg::*;

  localparam int NW  = LEVEL_BITS + SPAN_W;
  localparam int LNW = 23;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LDIV   = 3'd1;
  localparam logic [2:0] ST_PREP   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_DSTART = 3'd4;
  localparam logic [2:0] ST_EDIV   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]  state;
  logic [15:0] lux_goal;
  logic [9:0]  ramp_step;
  logic [3:0]  enc_gain;
  logic [15:0] goal_temp;
  logic [6:0]  goal_level;
  logic [15:0] now_temp;
  logic [6:0]  now_level;
  logic [1:0]  lamp_mode;

  logic [12:0]       span_w;
  logic [12:0]       span_c;
  logic [6:0]        mreg;
  logic [2:0]        mcnt;
  logic [SPAN_W-1:0] acc_w;
  logic [SPAN_W-1:0] acc_c;

  logic accept;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;

  // tick
  logic [15:0] tdist;
  logic        snap;
  logic        tick_idle;
  logic [15:0] tick_temp;
  logic [6:0]  tick_level;

  always_comb begin
    tdist = (now_temp > goal_temp) ? now_temp - goal_temp : goal_temp - now_temp;
    snap  = (tdist < {5'b0, ramp_step, 1'b0});
    tick_idle = (now_temp == goal_temp) && (now_level == goal_level);
    if (snap) tick_temp = goal_temp;
    else if (now_temp < goal_temp) tick_temp = now_temp + {6'b0, ramp_step};
    else tick_temp = now_temp - {6'b0, ramp_step};
    if (now_level < goal_level) tick_level = now_level + 7'd1;
    else if (now_level > goal_level) tick_level = now_level - 7'd1;
    else tick_level = now_level;
  end

  // ambient boost
  logic           amb_go;
  logic [15:0]    lux_diff;
  logic [LNW-1:0] lux_ext;
  logic [LNW-1:0] lux_num;
  logic           lux_done;
  logic [LNW-1:0] lux_quo;
  logic [7:0]     amb_sum;
  logic [6:0]     amb_lvl;

  always_comb begin
    amb_go   = (lamp_mode == MODE_AUTO) && (lux_goal != '0) && (item.lux_sample < lux_goal);
    lux_diff = lux_goal - item.lux_sample;
    lux_ext  = LNW'(lux_diff);
    lux_num  = (lux_ext << 6) + (lux_ext << 5) + (lux_ext << 2);
    amb_sum  = {1'b0, goal_level} + {2'b0, lux_quo[6:1]};
    amb_lvl  = (amb_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : amb_sum[6:0];
  end

  cct_sdiv #(.NW(LNW), .DW(16)) u_lux_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (item.action == ACT_AMBIENT) && amb_go),
    .num   (lux_num),
    .den   (lux_goal),
    .done  (lux_done),
    .quo   (lux_quo)
  );

  // encoder
  logic signed [12:0] enc_prod;
  logic signed [12:0] enc_sum;
  logic [6:0]         enc_lvl;

  always_comb begin
    enc_prod = 13'(item.encoder_delta) * $signed({9'b0, enc_gain});
    enc_sum  = enc_prod + $signed({6'b0, goal_level});
    if (enc_sum < 0) enc_lvl = '0;
    else if (enc_sum > $signed({6'b0, LEVEL_MAX})) enc_lvl = LEVEL_MAX;
    else enc_lvl = enc_sum[6:0];
  end

  // button
  logic [15:0] btn_temp;
  always_comb begin
    priority if (goal_temp < BTN_LOW_K) btn_temp = BTN_NEXT_K;
    else if (goal_temp < BTN_MID_K) btn_temp = COOL_K;
    else btn_temp = WARM_K;
  end

  // blend
  logic [15:0] tclamp;
  always_comb begin
    priority if (now_temp < WARM_K) tclamp = WARM_K;
    else if (now_temp > COOL_K) tclamp = COOL_K;
    else tclamp = now_temp;
  end

  logic          div_start;
  logic [NW-1:0] num_w;
  logic [NW-1:0] num_c;
  logic          w_done;
  logic          c_done;
  logic [NW-1:0] quo_w;
  logic [NW-1:0] quo_c;

  // FS * p = (p << LEVEL_BITS) - p
  assign div_start = (state == ST_DSTART);
  assign num_w     = {acc_w, {LEVEL_BITS{1'b0}}} - NW'(acc_w);
  assign num_c     = {acc_c, {LEVEL_BITS{1'b0}}} - NW'(acc_c);

  cct_sdiv #(.NW(NW), .DW(SPAN_W)) u_warm_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_w),
    .den   (SPAN_DEN),
    .done  (w_done),
    .quo   (quo_w)
  );

  cct_sdiv #(.NW(NW), .DW(SPAN_W)) u_cool_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_c),
    .den   (SPAN_DEN),
    .done  (c_done),
    .quo   (quo_c)
  );

  logic load_out;
  assign load_out = (state == ST_OUT) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      lux_goal  <= LUX_GOAL_RST;
      ramp_step <= RAMP_STEP_RST;
      enc_gain  <= ENC_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LUX_GOAL:  lux_goal  <= cfg_data;
        CFG_RAMP_STEP: ramp_step <= cfg_data[9:0];
        CFG_ENC_GAIN:  enc_gain  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      goal_temp    <= TEMP_RST;
      goal_level   <= LEVEL_RST;
      now_temp     <= TEMP_RST;
      now_level    <= LEVEL_RST;
      lamp_mode    <= MODE_AUTO;
      result_valid <= 1'b0;
    end else begin
      if (load_out) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (item.action)
              ACT_TICK: begin
                if (!tick_idle) begin
                  now_temp  <= tick_temp;
                  now_level <= tick_level;
                  state     <= ST_PREP;
                end
              end
              ACT_CMD: begin
                goal_temp  <= item.cmd_temp;
                goal_level <= (item.cmd_level > LEVEL_MAX) ? LEVEL_MAX : item.cmd_level;
                lamp_mode  <= item.cmd_mode;
              end
              ACT_AMBIENT: begin
                if (amb_go) state <= ST_LDIV;
              end
              ACT_ENCODER: begin
                if (item.encoder_delta != '0) begin
                  lamp_mode  <= MODE_MANUAL;
                  goal_level <= enc_lvl;
                  now_level  <= enc_lvl;
                  state      <= ST_PREP;
                end
              end
              ACT_BUTTON: begin
                lamp_mode <= MODE_MANUAL;
                goal_temp <= btn_temp;
                now_temp  <= btn_temp;
                state     <= ST_PREP;
              end
              default: ;
            endcase
          end
        end
        ST_LDIV: begin
          if (lux_done) begin
            if (amb_lvl != now_level) begin
              now_level <= amb_lvl;
              state     <= ST_PREP;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_PREP:   state <= ST_MUL;
        ST_MUL:    if (mcnt == 3'd1) state <= ST_DSTART;
        ST_DSTART: state <= ST_EDIV;
        ST_EDIV:   if (w_done) state <= ST_OUT;
        ST_OUT:    if (load_out) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  // serial span * level, one level bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      span_w <= 13'(COOL_K - tclamp);
      span_c <= 13'(tclamp - WARM_K);
      mreg   <= now_level;
      mcnt   <= 3'd7;
      acc_w  <= '0;
      acc_c  <= '0;
    end else if (state == ST_MUL) begin
      acc_w <= (acc_w << 1) + (mreg[6] ? SPAN_W'(span_w) : '0);
      acc_c <= (acc_c << 1) + (mreg[6] ? SPAN_W'(span_c) : '0);
      mreg  <= {mreg[5:0], 1'b0};
      mcnt  <= mcnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.warm_level  <= 16'(quo_w[LEVEL_BITS-1:0]);
      result.cool_level  <= 16'(quo_c[LEVEL_BITS-1:0]);
      result.shown_temp  <= now_temp;
      result.shown_level <= now_level;
    end
  end

`ifndef SYNTHESIS
  a_levels_fit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.warm_level} + {1'b0, result.cool_level})
                     <= 17'((1 << LEVEL_BITS) - 1))
    else $error("warm + cool exceeds full scale");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (now_level <= LEVEL_MAX) && (goal_level <= LEVEL_MAX))
    else $error("brightness out of range");

  a_lux_done_state: assert property (@(posedge clk) disable iff (rst)
    lux_done |-> (state == ST_LDIV))
    else $error("lux divide finished outside its wait state");

  a_blend_done: assert property (@(posedge clk) disable iff (rst)
    w_done |-> (c_done && (state == ST_EDIV)))
    else $error("blend dividers out of step");
`endif

endmodule

`default_nettype wire

@@ rtl/core/cct_sdiv.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module cct_sdiv #(
  parameter int NW = 35,
  parameter int DW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] sh;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          take;

  assign trial = {rem, sh[NW-1]};
  assign take  = (trial >= {1'b0, den});
  assign quo   = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  // partial remainder stays below den, so it fits DW bits
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= num;
      rem <= '0;
    end else if (cnt != '0) begin
      sh  <= {sh[NW-2:0], take};
      rem <= take ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
  import cct_pkg::*;

  localparam int LEVEL_BITS  = 16;
  localparam int ITEM_W      = $bits(item_t);
  localparam int SETTLE      = 100;     // longer than an ambient boost
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [1:0] MODE_CIRCADIAN = 2'd2;
  localparam logic [1:0] MODE_READING   = 2'd3;
  localparam logic [2:0] ACT_SPARE5     = 3'd5;
  localparam logic [2:0] ACT_SPARE6     = 3'd6;
  localparam logic [2:0] ACT_SPARE7     = 3'd7;

  typedef enum {CHK_MODEL, CHK_FIXED, CHK_NONE} check_t;

  typedef struct {
    item_t   ev;
    check_t  how;
    result_t want;
  } plan_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // lamp state as the block should hold it
  logic [15:0] tgt_temp   = TEMP_RST;
  logic [6:0]  tgt_level  = LEVEL_RST;
  logic [15:0] cur_temp   = TEMP_RST;
  logic [6:0]  cur_level  = LEVEL_RST;
  logic [1:0]  lamp_mode  = MODE_AUTO;
  logic [15:0] lux_target = LUX_GOAL_RST;
  logic [9:0]  ramp_k     = RAMP_STEP_RST;
  logic [3:0]  enc_gain   = ENC_GAIN_RST;

  result_t   levels_due[$];
  plan_row_t plan[$];
  int mismatches  = 0;
  int beats_seen  = 0;
  int cycle_count = 0;
  int gap_pct     = 20;
  int stall_pct   = 20;
  int stall_left  = 0;

  cct_lamp_dimming_controller #(.LEVEL_BITS(LEVEL_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("tb: beat %0d %s", beats_seen, what);
  endtask

  // Advance the lamp state by one event; returns 1 when a level beat is due.
  function automatic bit lamp_event(input item_t ev, output result_t beat);
    int temp_gap;
    int lvl;
    int boost;
    longint unsigned t;
    longint unsigned fs;
    bit fired;
    fired = 1'b0;
    beat = '0;
    case (ev.action)
      ACT_TICK: begin
        if (cur_temp != tgt_temp || cur_level != tgt_level) begin
          temp_gap = cur_temp > tgt_temp ? int'(cur_temp) - int'(tgt_temp)
                                         : int'(tgt_temp) - int'(cur_temp);
          if (temp_gap < 2 * int'(ramp_k)) cur_temp = tgt_temp;
          else if (cur_temp < tgt_temp) cur_temp = cur_temp + 16'(ramp_k);
          else cur_temp = cur_temp - 16'(ramp_k);
          if (cur_level < tgt_level) cur_level = cur_level + 7'd1;
          else if (cur_level > tgt_level) cur_level = cur_level - 7'd1;
          fired = 1'b1;
        end
      end
      ACT_CMD: begin
        tgt_temp  = ev.cmd_temp;
        tgt_level = ev.cmd_level > LEVEL_MAX ? LEVEL_MAX : ev.cmd_level;
        lamp_mode = ev.cmd_mode;
      end
      ACT_AMBIENT: begin
        if (lamp_mode == MODE_AUTO && lux_target != 0 && ev.lux_sample < lux_target) begin
          boost = (int'(lux_target) - int'(ev.lux_sample)) * 100 / int'(lux_target);
          lvl = int'(tgt_level) + boost / 2;
          if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
          if (lvl != int'(cur_level)) begin
            cur_level = 7'(lvl);
            fired = 1'b1;
          end
        end
      end
      ACT_ENCODER: begin
        if (ev.encoder_delta != 0) begin
          lamp_mode = MODE_MANUAL;
          lvl = int'(tgt_level) + int'(ev.encoder_delta) * int'(enc_gain);
          if (lvl < 0) lvl = 0;
          if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
          tgt_level = 7'(lvl);
          cur_level = 7'(lvl);
          fired = 1'b1;
        end
      end
      ACT_BUTTON: begin
        lamp_mode = MODE_MANUAL;
        if (tgt_temp < BTN_LOW_K) tgt_temp = BTN_NEXT_K;
        else if (tgt_temp < BTN_MID_K) tgt_temp = COOL_K;
        else tgt_temp = WARM_K;
        cur_temp = tgt_temp;
        fired = 1'b1;
      end
      default: ;
    endcase
    if (fired) begin
      fs = (64'd1 << LEVEL_BITS) - 64'd1;
      t = cur_temp;
      if (t < WARM_K) t = WARM_K;
      if (t > COOL_K) t = COOL_K;
      beat.warm_level  = 16'(fs * (COOL_K - t) * cur_level / SPAN_DEN);
      beat.cool_level  = 16'(fs * (t - WARM_K) * cur_level / SPAN_DEN);
      beat.shown_temp  = cur_temp;
      beat.shown_level = cur_level;
    end
    return fired;
  endfunction

  function automatic plan_row_t plan_row(check_t how, logic [2:0] act, logic [15:0] temp,
                                         logic [6:0] lvl, logic [1:0] md, logic [15:0] lux,
                                         logic signed [7:0] dlt, result_t want);
    plan_row_t r;
    r.ev.action        = act;
    r.ev.cmd_temp      = temp;
    r.ev.cmd_level     = lvl;
    r.ev.cmd_mode      = md;
    r.ev.lux_sample    = lux;
    r.ev.encoder_delta = dlt;
    r.how  = how;
    r.want = want;
    return r;
  endfunction

  // Present one event, hold it until taken, then book the expected beat.
  task automatic offer(item_t ev, check_t how, result_t want);
    result_t beat;
    bit fired;
    item <= ev;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    fired = lamp_event(ev, beat);
    if (how == CHK_FIXED) levels_due.push_back(want);
    else if (how == CHK_MODEL && fired) levels_due.push_back(beat);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain;
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] lux, logic [9:0] step, logic [3:0] gain);
    logic [1:0]  regs[3];
    logic [15:0] vals[3];
    regs = '{CFG_LUX_GOAL, CFG_RAMP_STEP, CFG_ENC_GAIN};
    vals = '{lux, 16'(step), 16'(gain)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    lux_target = lux;
    ramp_k     = step;
    enc_gain   = gain;
  endtask

  // Level beat sink with random back-pressure bursts.
  always @(posedge clk) begin
    result_t want;
    if (result_valid && !result_stall) begin
      if (levels_due.size() == 0) begin
        flag_mismatch("arrived with nothing outstanding");
      end else begin
        want = levels_due.pop_front();
        if (result.warm_level !== want.warm_level)
          flag_mismatch($sformatf("warm_level %0d, expected %0d",
                                  result.warm_level, want.warm_level));
        if (result.cool_level !== want.cool_level)
          flag_mismatch($sformatf("cool_level %0d, expected %0d",
                                  result.cool_level, want.cool_level));
        if (result.shown_temp !== want.shown_temp)
          flag_mismatch($sformatf("shown_temp %0d, expected %0d",
                                  result.shown_temp, want.shown_temp));
        if (result.shown_level !== want.shown_level)
          flag_mismatch($sformatf("shown_level %0d, expected %0d",
                                  result.shown_level, want.shown_level));
      end
      beats_seen++;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  initial begin
    item_t ev;
    int count;
    int pick;
    int tmp;
    logic [15:0] lux;
    logic [9:0]  step;
    logic [3:0]  gain;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // button cycle from reset, encoder extremes, then ramps and ambient boost
    plan.push_back(plan_row(CHK_FIXED, ACT_BUTTON, 0, 0, 0, 0, 0,
                            '{16'd0, 16'd39321, 16'd6500, 7'd60}));
    plan.push_back(plan_row(CHK_FIXED, ACT_BUTTON, 0, 0, 0, 0, 0,
                            '{16'd39321, 16'd0, 16'd1800, 7'd60}));
    plan.push_back(plan_row(CHK_FIXED, ACT_BUTTON, 0, 0, 0, 0, 0,
                            '{16'd16732, 16'd22588, 16'd4500, 7'd60}));
    plan.push_back(plan_row(CHK_FIXED, ACT_ENCODER, 0, 0, 0, 0, 8'sd127,
                            '{16'd27887, 16'd37647, 16'd4500, 7'd100}));
    plan.push_back(plan_row(CHK_FIXED, ACT_ENCODER, 0, 0, 0, 0, -8'sd128,
                            '{16'd0, 16'd0, 16'd4500, 7'd0}));
    plan.push_back(plan_row(CHK_NONE, ACT_ENCODER, 0, 0, 0, 0, 0, '0));
    // already at target: tick is silent
    plan.push_back(plan_row(CHK_NONE, ACT_TICK, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_CMD, 16'hFFFF, 7'd127, MODE_AUTO, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_TICK, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_AMBIENT, 0, 0, 0, 16'd0, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_AMBIENT, 0, 0, 0, 16'hFFFF, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_AMBIENT, 0, 0, 0, LUX_GOAL_RST, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_AMBIENT, 0, 0, 0, LUX_GOAL_RST - 16'd1, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_CMD, 16'd0, 7'd0, MODE_READING, 0, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_AMBIENT, 0, 0, 0, 16'd0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_TICK, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_TICK, 0, 0, 0, 0, 0, '0));
    // within two steps of target: temperature snaps
    plan.push_back(plan_row(CHK_NONE, ACT_CMD, 16'd4505, 7'd101, MODE_CIRCADIAN, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_TICK, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_SPARE5, 16'hFFFF, 7'h7F, 2'h3, 16'hFFFF, -8'sd1, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_SPARE6, 16'hFFFF, 7'h7F, 2'h3, 16'hFFFF, -8'sd1, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_SPARE7, 16'hFFFF, 7'h7F, 2'h3, 16'hFFFF, -8'sd1, '0));
    plan.push_back(plan_row(CHK_NONE, ACT_CMD, BTN_LOW_K - 16'd1, 7'd50, MODE_AUTO, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_BUTTON, 0, 0, 0, 0, 0, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_ENCODER, 0, 0, 0, 0, 8'sd1, '0));
    plan.push_back(plan_row(CHK_MODEL, ACT_AMBIENT, 0, 0, 0, 16'd250, 0, '0));
    foreach (plan[i]) offer(plan[i].ev, plan[i].how, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      item_valid <= 1'b0;
      drain();
      case (ph)
        0: begin lux = 16'd1;     step = 10'd1;    gain = 4'd1;  gap_pct = 30; stall_pct = 30; end
        1: begin lux = 16'hFFFF;  step = 10'd1000; gain = 4'd10; gap_pct = 10; stall_pct = 40; end
        // zero lux goal and zero ramp step
        2: begin lux = 16'd0;     step = 10'd0;    gain = 4'd10; gap_pct = 40; stall_pct = 10; end
        3: begin
          lux  = 16'($urandom_range(1, 65535));
          step = 10'($urandom_range(1, 1000));
          gain = 4'($urandom_range(1, 10));
          gap_pct = 15 * $urandom_range(0, 2);
          stall_pct = 15 * $urandom_range(0, 2);
        end
        4: begin
          lux  = 16'($urandom_range(100, 2000));
          step = 10'($urandom_range(1, 50));
          gain = 4'($urandom_range(1, 10));
          gap_pct = 15 * $urandom_range(0, 2);
          stall_pct = 15 * $urandom_range(0, 2);
        end
        default: begin
          lux = LUX_GOAL_RST; step = RAMP_STEP_RST; gain = ENC_GAIN_RST;
          gap_pct = 0; stall_pct = 0;
        end
      endcase
      set_regs(lux, step, gain);
      count = 0;
      while (count < PHASE_ITEMS) begin
        ev = item_t'(ITEM_W'({$urandom(), $urandom()}));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          ev.action = ACT_TICK;
        end else if (pick < 55) begin
          ev.action = ACT_CMD;
          case ($urandom_range(0, 5))
            0: ev.cmd_temp = 16'($urandom_range(1500, 7000));
            1: begin
              // near the present temperature so that ramps finish
              tmp = int'(cur_temp) + int'($urandom_range(0, 40)) - 20;
              if (tmp < 0) tmp = 0;
              if (tmp > 65535) tmp = 65535;
              ev.cmd_temp = 16'(tmp);
            end
            2: ;
            3: ev.cmd_temp = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            4: ev.cmd_temp = $urandom_range(0, 1) ? WARM_K : COOL_K;
            default: ev.cmd_temp = $urandom_range(0, 1) ? BTN_LOW_K - 16'd1 : BTN_MID_K;
          endcase
          ev.cmd_level = 7'($urandom_range(0, 127));
          ev.cmd_mode = $urandom_range(0, 1) ? MODE_AUTO : 2'($urandom_range(1, 3));
        end else if (pick < 75) begin
          ev.action = ACT_AMBIENT;
          case ($urandom_range(0, 4))
            0: ev.lux_sample = 16'd0;
            1: ev.lux_sample = lux_target == 0 ? 16'd0 : lux_target - 16'd1;
            2: ev.lux_sample = lux_target;
            3: ev.lux_sample = 16'($urandom_range(0, int'(lux_target)));
            default: ;
          endcase
        end else if (pick < 87) begin
          ev.action = ACT_ENCODER;
          tmp = $urandom_range(0, 9);
          if (tmp == 0) ev.encoder_delta = 8'sd0;
          else if (tmp < 7) ev.encoder_delta = 8'(int'($urandom_range(0, 10)) - 5);
        end else if (pick < 95) begin
          ev.action = ACT_BUTTON;
        end else begin
          ev.action = 3'($urandom_range(ACT_SPARE5, ACT_SPARE7));
        end
        offer(ev, CHK_MODEL, '0);
        if (ev.action <= ACT_BUTTON) count++;
        if (ph == 3 && count == PHASE_ITEMS / 2) begin
          item_valid <= 1'b0;
          do @(posedge clk); while (levels_due.size() != 0);
        end
      end
    end

    item_valid <= 1'b0;
    drain();
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ cct_lamp_dimming_controller.f @@
rtl/core/cct_pkg.sv
rtl/core/cct_sdiv.sv
rtl/core/cct_lamp_dimming_controller.sv
tb/testbench.sv
